/* rtl/core/ypp_pkg.sv */
// ----------------------------------------------------------------------------
// ypp_pkg
// Shared widths, register indexes, pipeline types and the sine table
// generator for the yaw/pitch perspective projection block.
// ----------------------------------------------------------------------------
package ypp_pkg;

	// default parameter values
	localparam int NEAR_PLANE_DEF = 26;
	localparam int TRIG_BITS_DEF  = 10;

	// field widths
	localparam int CW   = 24;  // world coordinate, Q15.8
	localparam int RW   = 25;  // point minus camera
	localparam int AW   = 16;  // binary angle
	localparam int TW   = 16;  // Q1.14 sine / cosine
	localparam int FW   = 16;  // focal length
	localparam int VW   = 13;  // viewport size
	localparam int XW   = 28;  // after yaw rotation
	localparam int ZW   = 31;  // after pitch rotation
	localparam int NXW  = 45;  // x1 * focal
	localparam int NYW  = 48;  // y2 * focal
	localparam int NW   = 56;  // numerator incl. the 256 scale
	localparam int DW   = 30;  // divisor / remainder
	localparam int QB   = 26;  // quotient bits kept, more saturates anyway
	localparam int DEPW = 25;  // view depth
	localparam int IW   = 3;   // register index

	// register indexes
	localparam logic [IW-1:0] REG_CAMERA_X    = 3'd0;
	localparam logic [IW-1:0] REG_CAMERA_Y    = 3'd1;
	localparam logic [IW-1:0] REG_CAMERA_Z    = 3'd2;
	localparam logic [IW-1:0] REG_YAW         = 3'd3;
	localparam logic [IW-1:0] REG_PITCH       = 3'd4;
	localparam logic [IW-1:0] REG_FOCAL       = 3'd5;
	localparam logic [IW-1:0] REG_VIEW_WIDTH  = 3'd6;
	localparam logic [IW-1:0] REG_VIEW_HEIGHT = 3'd7;

	// result of the transform pipeline, fed to the divider
	typedef struct packed {
		logic                  vis;
		logic signed [NXW-1:0] nx;
		logic signed [NYW-1:0] ny;
		logic signed [ZW-1:0]  z2;
	} xf_res_t;

	// one divider lane
	typedef struct packed {
		logic [DW-1:0] rem;
		logic [QB-1:0] low;
		logic [QB-1:0] quo;
		logic          neg;
		logic          ovf;
	} div_lane_t;

	// data that rides along the divider
	typedef struct packed {
		logic                   vis;
		logic signed [DEPW-1:0] depth;
		logic [DW-1:0]          den;
	} div_side_t;

	// quarter-wave sine entry, Q1.14 in 0..16384 (elaboration only)
	// Taylor terms up to theta^15, factorial steps 2*3 through 14*15
	function automatic logic [TW-1:0] quarter_sine(input int unsigned j,
		input int unsigned tb);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		x    = (64'(j) * 64'd1686629713) >> (tb - 2);
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd210;
		sum  = sum - $signed(term);
		if (sum < 0)
			sum = 0;
		sum = (sum + 64'sd32768) >>> 16;
		if (sum > 64'sd16384)
			sum = 64'sd16384;
		return sum[TW-1:0];
	endfunction

endpackage

/* rtl/core/ypp_trig.sv */
// ----------------------------------------------------------------------------
// ypp_trig
// Registered sine and cosine of the negated camera angle from a
// quarter-wave constant table.
// ----------------------------------------------------------------------------
module ypp_trig #(
	parameter int TRIG_TABLE_BITS = ypp_pkg::TRIG_BITS_DEF
) (
	input  logic                           clk,
	input  logic [ypp_pkg::AW-1:0]         angle,
	output logic signed [ypp_pkg::TW-1:0]  sin_val,
	output logic signed [ypp_pkg::TW-1:0]  cos_val
);
	import ypp_pkg::*;

	localparam int RB = TRIG_TABLE_BITS - 2;
	localparam int QN = 1 << RB;

	logic [TW-1:0] qtab [0:QN];
	logic [AW-1:0] neg_angle;
	logic [AW-1:0] cos_angle;
	logic signed [TW-1:0] sin_d;
	logic signed [TW-1:0] cos_d;

	// constant quarter-wave table
	for (genvar j = 0; j <= QN; j++) begin : g_tab
		assign qtab[j] = quarter_sine(j, TRIG_TABLE_BITS);
	end

	// full-turn lookup by quadrant folding
	function automatic logic signed [TW-1:0] lookup(input logic [AW-1:0] a);
		logic [TRIG_TABLE_BITS-1:0] idx;
		logic [1:0]                 quad;
		logic [RB:0]                ri;
		logic signed [TW-1:0]       mag;
		idx  = a[AW-1 -: TRIG_TABLE_BITS];
		quad = idx[TRIG_TABLE_BITS-1 -: 2];
		if (quad[0])
			ri = (RB+1)'(QN) - {1'b0, idx[RB-1:0]};
		else
			ri = {1'b0, idx[RB-1:0]};
		mag = $signed(qtab[ri]);
		return quad[1] ? -mag : mag;
	endfunction

	assign neg_angle = AW'(0) - angle;
	assign cos_angle = neg_angle + AW'(16384);

	always_comb begin
		sin_d = lookup(neg_angle);
		cos_d = lookup(cos_angle);
	end

	always_ff @(posedge clk) begin
		sin_val <= sin_d;
		cos_val <= cos_d;
	end

endmodule

/* rtl/core/ypp_xform.sv */
// ----------------------------------------------------------------------------
// ypp_xform
// Six-stage pipeline: camera offset, yaw rotation, pitch rotation and the
// focal scaling of the projection numerators.
// ----------------------------------------------------------------------------
module ypp_xform #(
	parameter int NEAR_PLANE = ypp_pkg::NEAR_PLANE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [ypp_pkg::CW-1:0] point_x,
	input  logic signed [ypp_pkg::CW-1:0] point_y,
	input  logic signed [ypp_pkg::CW-1:0] point_z,
	input  logic signed [ypp_pkg::CW-1:0] cam_x,
	input  logic signed [ypp_pkg::CW-1:0] cam_y,
	input  logic signed [ypp_pkg::CW-1:0] cam_z,
	input  logic signed [ypp_pkg::TW-1:0] sin_yaw,
	input  logic signed [ypp_pkg::TW-1:0] cos_yaw,
	input  logic signed [ypp_pkg::TW-1:0] sin_pitch,
	input  logic signed [ypp_pkg::TW-1:0] cos_pitch,
	input  logic [ypp_pkg::FW-1:0]        focal,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ypp_pkg::xf_res_t              out_res
);
	import ypp_pkg::*;

	localparam int NS = 6;
	localparam logic signed [ZW-1:0] NEAR_Z = ZW'(NEAR_PLANE);

	logic [NS-1:0] v_q;
	logic [NS-1:0] adv;

	logic signed [RW-1:0] rx_s1, ry_s1, rz_s1;
	logic signed [RW+TW-1:0] pcx_s2, psz_s2, pcz_s2, psx_s2;
	logic signed [RW-1:0] ry_s2;
	logic signed [XW-1:0] x1_s3, z1_s3;
	logic signed [RW-1:0] ry_s3;
	logic signed [RW+TW-1:0] pcy_s4, psy_s4;
	logic signed [XW+TW-1:0] psz_s4, pcz_s4;
	logic signed [XW-1:0] x1_s4;
	logic signed [ZW-1:0] y2_s5, z2_s5;
	logic signed [XW-1:0] x1_s5;
	xf_res_t res_s6;

	logic signed [RW+TW:0]   xs, zs;
	logic signed [XW+TW:0]   ys, zs2;
	logic signed [FW:0]      focal_s;

	// stall ripple: a stage moves when it is empty or the next one moves
	always_comb begin
		adv[NS-1] = ~v_q[NS-1] | out_ready;
		for (int i = NS - 2; i >= 0; i--)
			adv[i] = ~v_q[i] | adv[i+1];
	end

	assign in_ready  = adv[0];
	assign out_valid = v_q[NS-1];
	assign out_res   = res_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[0])
				v_q[0] <= in_valid;
			for (int i = 1; i < NS; i++)
				if (adv[i])
					v_q[i] <= v_q[i-1];
		end
	end

	// rounded rotation sums
	always_comb begin
		xs      = pcx_s2 + psz_s2 + (RW+TW+1)'(8192);
		zs      = pcz_s2 - psx_s2 + (RW+TW+1)'(8192);
		ys      = pcy_s4 - psz_s4 + (XW+TW+1)'(8192);
		zs2     = psy_s4 + pcz_s4 + (XW+TW+1)'(8192);
		focal_s = $signed({1'b0, focal});
	end

	// data path
	always_ff @(posedge clk) begin
		// s1: camera offset
		if (adv[0]) begin
			rx_s1 <= RW'(point_x) - RW'(cam_x);
			ry_s1 <= RW'(point_y) - RW'(cam_y);
			rz_s1 <= RW'(point_z) - RW'(cam_z);
		end
		// s2: yaw products
		if (adv[1]) begin
			pcx_s2 <= cos_yaw * rx_s1;
			psz_s2 <= sin_yaw * rz_s1;
			pcz_s2 <= cos_yaw * rz_s1;
			psx_s2 <= sin_yaw * rx_s1;
			ry_s2  <= ry_s1;
		end
		// s3: yaw sums, sign kept in the top bit
		if (adv[2]) begin
			x1_s3 <= xs[RW+TW:14];
			z1_s3 <= zs[RW+TW:14];
			ry_s3 <= ry_s2;
		end
		// s4: pitch products
		if (adv[3]) begin
			pcy_s4 <= cos_pitch * ry_s3;
			psz_s4 <= sin_pitch * z1_s3;
			psy_s4 <= sin_pitch * ry_s3;
			pcz_s4 <= cos_pitch * z1_s3;
			x1_s4  <= x1_s3;
		end
		// s5: pitch sums
		if (adv[4]) begin
			y2_s5 <= ys[XW+TW:14];
			z2_s5 <= zs2[XW+TW:14];
			x1_s5 <= x1_s4;
		end
		// s6: focal scaling and near-plane test
		if (adv[5]) begin
			res_s6.vis <= z2_s5 > NEAR_Z;
			res_s6.nx  <= x1_s5 * focal_s;
			res_s6.ny  <= y2_s5 * focal_s;
			res_s6.z2  <= z2_s5;
		end
	end

endmodule

/* rtl/core/ypp_div.sv */
// ----------------------------------------------------------------------------
// ypp_div
// Two-lane pipelined restoring divider, one quotient bit per stage, with
// screen offset, saturation and the output register.
// ----------------------------------------------------------------------------
module ypp_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  ypp_pkg::xf_res_t                 in_res,
	input  logic [ypp_pkg::VW-1:0]           view_w,
	input  logic [ypp_pkg::VW-1:0]           view_h,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             visible,
	output logic signed [ypp_pkg::CW-1:0]    screen_x,
	output logic signed [ypp_pkg::CW-1:0]    screen_y,
	output logic signed [ypp_pkg::DEPW-1:0]  view_depth
);
	import ypp_pkg::*;

	// prep, QB steps, output register
	localparam int NS  = QB + 2;
	localparam int SUW = QB + 2;

	logic [NS-1:0] v_q;
	logic [NS-1:0] adv;

	div_lane_t lx_q [0:QB];
	div_lane_t ly_q [0:QB];
	div_side_t side_q [0:QB];
	div_lane_t nlx [1:QB];
	div_lane_t nly [1:QB];

	div_lane_t prep_x, prep_y;
	div_side_t prep_side;

	logic                   vis_q;
	logic signed [CW-1:0]   sx_q, sy_q;
	logic signed [DEPW-1:0] dep_q;
	logic signed [CW-1:0]   fin_x, fin_y;

	// lane setup: magnitude, high part and overflow check
	function automatic div_lane_t prep(input logic [NW-1:0] n, input logic [DW-1:0] d);
		logic [NW-1:0] a;
		div_lane_t     o;
		a     = n[NW-1] ? (NW'(0) - n) : n;
		o.neg = n[NW-1];
		o.rem = a[NW-1:QB];
		o.low = a[QB-1:0];
		o.quo = '0;
		o.ovf = a[NW-1:QB] >= d;
		return o;
	endfunction

	// one restoring step
	function automatic div_lane_t step(input div_lane_t l, input logic [DW-1:0] d);
		logic [DW:0] t;
		logic        ge;
		div_lane_t   o;
		t     = {l.rem, l.low[QB-1]};
		ge    = t >= {1'b0, d};
		o     = l;
		o.rem = ge ? DW'(t - {1'b0, d}) : t[DW-1:0];
		o.low = {l.low[QB-2:0], 1'b0};
		o.quo = {l.quo[QB-2:0], ge};
		return o;
	endfunction

	// signed quotient plus screen center, saturated
	function automatic logic signed [CW-1:0] finish(input div_lane_t l,
		input logic [VW-1:0] size);
		logic [QB-1:0]         qm;
		logic signed [SUW-1:0] q;
		logic signed [SUW-1:0] s;
		qm = l.ovf ? '1 : l.quo;
		q  = l.neg ? -$signed({2'b00, qm}) : $signed({2'b00, qm});
		s  = q + $signed(SUW'({size, 7'b0}));
		if (s > $signed(SUW'({1'b0, {(CW-1){1'b1}}})))
			return {1'b0, {(CW-1){1'b1}}};
		else if (s < -$signed(SUW'({1'b1, {(CW-1){1'b0}}})))
			return {1'b1, {(CW-1){1'b0}}};
		else
			return s[CW-1:0];
	endfunction

	always_comb begin
		adv[NS-1] = ~v_q[NS-1] | out_ready;
		for (int i = NS - 2; i >= 0; i--)
			adv[i] = ~v_q[i] | adv[i+1];
	end

	assign in_ready   = adv[0];
	assign out_valid  = v_q[NS-1];
	assign visible    = vis_q;
	assign screen_x   = sx_q;
	assign screen_y   = sy_q;
	assign view_depth = dep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[0])
				v_q[0] <= in_valid;
			for (int i = 1; i < NS; i++)
				if (adv[i])
					v_q[i] <= v_q[i-1];
		end
	end

	// prep stage inputs and depth saturation
	always_comb begin
		prep_side.den = in_res.z2[DW-1:0];
		prep_side.vis = in_res.vis;
		if ((&in_res.z2[ZW-1:DEPW-1]) || ~(|in_res.z2[ZW-1:DEPW-1]))
			prep_side.depth = in_res.z2[DEPW-1:0];
		else
			prep_side.depth = {in_res.z2[ZW-1], {(DEPW-1){~in_res.z2[ZW-1]}}};
		prep_x = prep({{(NW-NXW-8){in_res.nx[NXW-1]}}, in_res.nx, 8'b0},
			prep_side.den);
		prep_y = prep({in_res.ny, 8'b0}, prep_side.den);
	end

	// quotient steps
	always_comb begin
		for (int k = 1; k <= QB; k++) begin
			nlx[k] = step(lx_q[k-1], side_q[k-1].den);
			nly[k] = step(ly_q[k-1], side_q[k-1].den);
		end
	end

	always_comb begin
		fin_x = finish(lx_q[QB], view_w);
		fin_y = finish(ly_q[QB], view_h);
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			lx_q[0]   <= prep_x;
			ly_q[0]   <= prep_y;
			side_q[0] <= prep_side;
		end
		for (int k = 1; k <= QB; k++) begin
			if (adv[k]) begin
				lx_q[k]   <= nlx[k];
				ly_q[k]   <= nly[k];
				side_q[k] <= side_q[k-1];
			end
		end
		// output register
		if (adv[NS-1]) begin
			vis_q <= side_q[QB].vis;
			sx_q  <= side_q[QB].vis ? fin_x : '0;
			sy_q  <= side_q[QB].vis ? fin_y : '0;
			dep_q <= side_q[QB].depth;
		end
	end

endmodule

/* rtl/core/yaw_pitch_perspective_project.sv */
// From input transaction to result: 6 transform stages, divider setup,
// 26 quotient stages, output register. Throughput: one point per cycle
// while the output is not stalled; the 26-stage bit-per-stage divider sets the depth.
// Stalls ripple back stage by stage, so empty stages keep filling.
// Reset (arst_n, async, active low) empties the pipeline and loads the
// register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
// yaw_pitch_perspective_project
// Camera-space transform and perspective projection of streamed points.
// ----------------------------------------------------------------------------
module yaw_pitch_perspective_project #(
	parameter int NEAR_PLANE      = ypp_pkg::NEAR_PLANE_DEF,
	parameter int TRIG_TABLE_BITS = ypp_pkg::TRIG_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [ypp_pkg::IW-1:0]           cfg_index,
	input  logic [ypp_pkg::CW-1:0]           cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [ypp_pkg::CW-1:0]    point_x,
	input  logic signed [ypp_pkg::CW-1:0]    point_y,
	input  logic signed [ypp_pkg::CW-1:0]    point_z,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             visible,
	output logic signed [ypp_pkg::CW-1:0]    screen_x,
	output logic signed [ypp_pkg::CW-1:0]    screen_y,
	output logic signed [ypp_pkg::DEPW-1:0]  view_depth
);
	import ypp_pkg::*;

	logic signed [CW-1:0] cam_x_q, cam_y_q, cam_z_q;
	logic [AW-1:0]        yaw_q, pitch_q;
	logic [FW-1:0]        focal_q;
	logic [VW-1:0]        view_w_q, view_h_q;

	logic signed [TW-1:0] sin_yaw, cos_yaw, sin_pitch, cos_pitch;
	logic                 xf_valid, xf_ready;
	xf_res_t              xf_res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q  <= '0;
			cam_y_q  <= '0;
			cam_z_q  <= '0;
			yaw_q    <= '0;
			pitch_q  <= '0;
			focal_q  <= FW'(500);
			view_w_q <= VW'(800);
			view_h_q <= VW'(600);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_CAMERA_X:    cam_x_q  <= cfg_data;
				REG_CAMERA_Y:    cam_y_q  <= cfg_data;
				REG_CAMERA_Z:    cam_z_q  <= cfg_data;
				REG_YAW:         yaw_q    <= cfg_data[AW-1:0];
				REG_PITCH:       pitch_q  <= cfg_data[AW-1:0];
				REG_FOCAL:       focal_q  <= cfg_data[FW-1:0];
				REG_VIEW_WIDTH:  view_w_q <= cfg_data[VW-1:0];
				REG_VIEW_HEIGHT: view_h_q <= cfg_data[VW-1:0];
				default: ;
			endcase
		end
	end

	// rotation coefficients
	ypp_trig #(.TRIG_TABLE_BITS(TRIG_TABLE_BITS)) u_trig_yaw (
		.clk     (clk),
		.angle   (yaw_q),
		.sin_val (sin_yaw),
		.cos_val (cos_yaw)
	);

	ypp_trig #(.TRIG_TABLE_BITS(TRIG_TABLE_BITS)) u_trig_pitch (
		.clk     (clk),
		.angle   (pitch_q),
		.sin_val (sin_pitch),
		.cos_val (cos_pitch)
	);

	// transform pipeline
	ypp_xform #(.NEAR_PLANE(NEAR_PLANE)) u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.cam_x     (cam_x_q),
		.cam_y     (cam_y_q),
		.cam_z     (cam_z_q),
		.sin_yaw   (sin_yaw),
		.cos_yaw   (cos_yaw),
		.sin_pitch (sin_pitch),
		.cos_pitch (cos_pitch),
		.focal     (focal_q),
		.out_valid (xf_valid),
		.out_ready (xf_ready),
		.out_res   (xf_res)
	);

	// divide and place on screen
	ypp_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (xf_valid),
		.in_ready   (xf_ready),
		.in_res     (xf_res),
		.view_w     (view_w_q),
		.view_h     (view_h_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.visible    (visible),
		.screen_x   (screen_x),
		.screen_y   (screen_y),
		.view_depth (view_depth)
	);

	// hidden points carry no screen position
	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !visible |-> screen_x == '0 && screen_y == '0)
		else $error("hidden point with nonzero screen position");

	// a visible point lies past the near plane
	a_visible_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && visible |-> !view_depth[DEPW-1] &&
			view_depth > DEPW'(NEAR_PLANE))
		else $error("visible point at or before near plane");

	// input back-pressure only comes from a full, stalled pipeline
	a_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while output is free");

endmodule

/* tb/ypp_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ypp_checker
// Watches the register port and both streaming channels of the projection
// block, predicts every projected point and compares results in order.
// ----------------------------------------------------------------------------
module ypp_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [ypp_pkg::IW-1:0]          cfg_index,
	input  logic [ypp_pkg::CW-1:0]          cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic signed [ypp_pkg::CW-1:0]   point_x,
	input  logic signed [ypp_pkg::CW-1:0]   point_y,
	input  logic signed [ypp_pkg::CW-1:0]   point_z,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic                            visible,
	input  logic signed [ypp_pkg::CW-1:0]   screen_x,
	input  logic signed [ypp_pkg::CW-1:0]   screen_y,
	input  logic signed [ypp_pkg::DEPW-1:0] view_depth,
	output int                              fail_count,
	output int                              pending
);
	import ypp_pkg::*;

	localparam int NEAR      = 26;
	localparam int TBITS     = 10;
	localparam int QSTEPS    = 1 << (TBITS - 2);

	typedef struct packed {
		logic                   vis;
		logic signed [CW-1:0]   sx;
		logic signed [CW-1:0]   sy;
		logic signed [DEPW-1:0] depth;
	} proj_t;

	proj_t projected_q[$];
	longint sine_lut[0:QSTEPS];

	// camera registers as the block should hold them
	logic signed [CW-1:0] cam_x, cam_y, cam_z;
	logic [AW-1:0]        yaw, pitch;
	logic [FW-1:0]        focal;
	logic [VW-1:0]        view_w, view_h;

	// quarter-wave sine by truncated Taylor series, Q30 rounded to Q14
	function automatic longint quarter_wave(int unsigned j);
		longint unsigned th, th2, term;
		longint          acc;
		th   = (longint'(j) * 64'd1686629713) >> (TBITS - 2);
		th2  = (th * th) >> 30;
		term = th;
		acc  = longint'(th);
		for (int k = 1; k <= 7; k++) begin
			term = ((term * th2) >> 30) / longint'((2 * k) * (2 * k + 1));
			if (k % 2 == 1)
				acc -= longint'(term);
			else
				acc += longint'(term);
		end
		if (acc < 0)
			acc = 0;
		acc = (acc + 32768) >>> 16;
		return (acc > 16384) ? 16384 : acc;
	endfunction

	function automatic longint lut_sine(logic [AW-1:0] ang);
		logic [TBITS-1:0] idx;
		int unsigned      r;
		idx = ang[AW-1 -: TBITS];
		r   = idx[TBITS-3:0];
		case (idx[TBITS-1 -: 2])
			2'd0:    return  sine_lut[r];
			2'd1:    return  sine_lut[QSTEPS - r];
			2'd2:    return -sine_lut[r];
			default: return -sine_lut[QSTEPS - r];
		endcase
	endfunction

	function automatic longint rotate(longint c, longint u, longint s, longint v);
		return (c * u + s * v + 8192) >>> 14;
	endfunction

	function automatic longint clamp(longint v, int w);
		longint hi, lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	function automatic proj_t project(longint px, longint py, longint pz);
		proj_t           res;
		longint          rx, ry, rz, sy, cy, sp, cp, x1, z1, y2, z2, f;
		logic [AW-1:0]   nyaw, npitch;
		rx     = px - longint'(cam_x);
		ry     = py - longint'(cam_y);
		rz     = pz - longint'(cam_z);
		nyaw   = -yaw;
		npitch = -pitch;
		sy     = lut_sine(nyaw);
		cy     = lut_sine(nyaw + 16'd16384);
		sp     = lut_sine(npitch);
		cp     = lut_sine(npitch + 16'd16384);
		x1     = rotate(cy, rx, sy, rz);
		z1     = rotate(cy, rz, -sy, rx);
		y2     = rotate(cp, ry, -sp, z1);
		z2     = rotate(sp, ry, cp, z1);
		res.vis = (z2 > NEAR);
		res.sx  = '0;
		res.sy  = '0;
		if (res.vis) begin
			f      = longint'(focal) * 256;
			res.sx = clamp((x1 * f) / z2 + longint'(view_w) * 128, CW);
			res.sy = clamp((y2 * f) / z2 + longint'(view_h) * 128, CW);
		end
		res.depth = clamp(z2, DEPW);
		return res;
	endfunction

	initial begin
		for (int j = 0; j <= QSTEPS; j++)
			sine_lut[j] = quarter_wave(j);
	end

	// register mirror, prediction on input transactions, compare on output ones
	always @(posedge clk or negedge arst_n) begin
		proj_t exp_r;
		if (!arst_n) begin
			cam_x      <= '0;
			cam_y      <= '0;
			cam_z      <= '0;
			yaw        <= '0;
			pitch      <= '0;
			focal      <= 16'd500;
			view_w     <= 13'd800;
			view_h     <= 13'd600;
			fail_count <= 0;
			pending    <= 0;
			projected_q.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_CAMERA_X:    cam_x  <= cfg_data;
					REG_CAMERA_Y:    cam_y  <= cfg_data;
					REG_CAMERA_Z:    cam_z  <= cfg_data;
					REG_YAW:         yaw    <= cfg_data[AW-1:0];
					REG_PITCH:       pitch  <= cfg_data[AW-1:0];
					REG_FOCAL:       focal  <= cfg_data[FW-1:0];
					REG_VIEW_WIDTH:  view_w <= cfg_data[VW-1:0];
					REG_VIEW_HEIGHT: view_h <= cfg_data[VW-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				projected_q.push_back(project(point_x, point_y, point_z));
			if (out_valid && out_ready) begin
				if (projected_q.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected result vis=%0b sx=%0d sy=%0d depth=%0d",
							$realtime, visible, screen_x, screen_y, view_depth);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = projected_q.pop_front();
					if (exp_r.vis !== visible || exp_r.sx !== screen_x ||
					    exp_r.sy !== screen_y || exp_r.depth !== view_depth) begin
						if (fail_count < 10)
							$display("%0t: mismatch exp vis=%0b sx=%0d sy=%0d depth=%0d,",
								$realtime, exp_r.vis, exp_r.sx, exp_r.sy, exp_r.depth,
								" got vis=%0b sx=%0d sy=%0d depth=%0d",
								visible, screen_x, screen_y, view_depth);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= projected_q.size();
		end
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the perspective projection block: register settings from
// identity to extremes, directed corner points, then randomized point
// streams with random gaps and back-pressure. The checker does the scoring.
// ----------------------------------------------------------------------------
module tb;
	import ypp_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [IW-1:0]          cfg_index = '0;
	logic [CW-1:0]          cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic signed [CW-1:0]   point_x = '0, point_y = '0, point_z = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   visible;
	logic signed [CW-1:0]   screen_x, screen_y;
	logic signed [DEPW-1:0] view_depth;
	int                     fail_count, pending;

	// knobs shared by the sender and the receiver
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	// current camera, used to aim points near it
	logic signed [CW-1:0] cam [3];

	always #5 clk = ~clk;

	yaw_pitch_perspective_project dut (.*);

	ypp_checker chk (.*);

	// one register write per cycle; the caller drops the enable afterwards
	task automatic write_reg(logic [IW-1:0] idx, logic [CW-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		if (idx <= REG_CAMERA_Z)
			cam[idx] = val;
	endtask

	// wait for the pipeline to drain before touching registers
	task automatic drain();
		wait (pending == 0);
		repeat (40) @(negedge clk);
	endtask

	task automatic send_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		point_x  <= x;
		point_y  <= y;
		point_z  <= z;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	function automatic logic [CW-1:0] near_coord(logic [CW-1:0] c);
		int span;
		span = 1 << $urandom_range(4, 20);
		return c + CW'($urandom_range(0, 2 * span) - span);
	endfunction

	task automatic random_point();
		int pick;
		logic [CW-1:0] v [3];
		pick = $urandom_range(0, 9);
		for (int i = 0; i < 3; i++) begin
			if (pick < 7)
				v[i] = near_coord(cam[i]);
			else if (pick < 9)
				v[i] = $urandom;
			else
				v[i] = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
		end
		send_point(v[0], v[1], v[2]);
	endtask

	// result side: random stalls, quiet stretches, one long hold-off
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_req = 1'b0;
			end
			w = quiet ? 0 : $urandom_range(0, 11);
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		logic [CW-1:0] settings [4][8];
		cam = '{default: '0};
		settings[0] = '{24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'd500, 24'd800, 24'd600};
		settings[1] = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'd16384, 24'hFFFF,
			24'hFFFF, 24'd4096, 24'd4096};
		settings[2] = '{24'h800000, 24'h800000, 24'h800000, 24'd32768, 24'd8192,
			24'd1, 24'd1, 24'd1};
		settings[3] = '{24'h000100, 24'hFFFF00, 24'h000800, 24'd49152, 24'd65535,
			24'd0, 24'd0, 24'd8191};

		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < 9; ph++) begin
			drain();
			for (int r = 0; r < 8; r++)
				write_reg(IW'(r), (ph < 4) ? settings[ph][r] : CW'($urandom));
			cfg_wr_en <= 1'b0;
			quiet = (ph % 3 == 1);
			if (ph == 0) begin
				// identity camera: near plane edge, field extremes, saturation
				send_point(24'd0, 24'd0, 24'd26);
				send_point(24'd0, 24'd0, 24'd27);
				send_point(24'd0, 24'd0, 24'd0);
				send_point(24'd100, -24'sd100, -24'sd500);
				send_point(24'h7FFFFF, 24'h7FFFFF, 24'd27);
				send_point(24'h800000, 24'h800000, 24'd27);
				send_point(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
				send_point(24'h800000, 24'h7FFFFF, 24'h800000);
				send_point(24'h5A5A5A, 24'hA5A5A5, 24'h123456);
				send_point(-24'sd2560, 24'd2560, 24'd256);
			end else if (ph == 2) begin
				// camera at the minimum corner: depth overflow both ways
				send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
				send_point(24'h800000, 24'h800000, 24'h800000);
				send_point(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
			end
			for (int n = 0; n < 190; n++) begin
				if (ph == 4 && n == 20)
					hold_req = 1'b1;
				if (ph == 5 && n == 50) begin
					in_valid <= 1'b0;
					wait (pending == 0);
					@(negedge clk);
				end
				if (n == 120)
					quiet = ~quiet;
				random_point();
			end
			in_valid <= 1'b0;
		end

		wait (pending == 0);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule

/* yaw_pitch_perspective_project.f */
rtl/core/ypp_pkg.sv
rtl/core/ypp_trig.sv
rtl/core/ypp_xform.sv
rtl/core/ypp_div.sv
rtl/core/yaw_pitch_perspective_project.sv
tb/ypp_checker.sv
tb/tb.sv
